### rtl/range_huge_page_splitter_macros.svh
// assertion macros used by the range splitter back end
`ifndef RANGE_HUGE_PAGE_SPLITTER_MACROS_SVH
`define RANGE_HUGE_PAGE_SPLITTER_MACROS_SVH

// same-cycle implication, checked on clk, off while in reset
`define RHPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while in reset
`define RHPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rhps_pkg.sv
// constants, widths and the chunk plan type of the range splitter
package rhps_pkg;

  localparam int unsigned PAGE_BYTES       = 4096;
  localparam int unsigned HUGE_SPAN_PAGES  = 512;
  localparam int unsigned MAX_LENGTH_BYTES = 67108864;
  localparam int unsigned ADDRESS_BITS     = 48;

  // page and huge span sizes are powers of two
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned HUGE_SHIFT = $clog2(HUGE_SPAN_PAGES);

  localparam int unsigned START_W = ADDRESS_BITS;
  localparam int unsigned LEN_W   = 27;
  localparam int unsigned PAGE_W  = ADDRESS_BITS - PAGE_SHIFT;
  localparam int unsigned IDX_W   = PAGE_W + 1;
  localparam int unsigned CNT_W   = 10;

  localparam int unsigned QUEUE_DEPTH = 2;

  // chunk kinds in emission order
  localparam int unsigned SEG_LEDGE = 0;
  localparam int unsigned SEG_PLAIN = 1;
  localparam int unsigned SEG_HUGE  = 2;
  localparam int unsigned SEG_POST  = 3;
  localparam int unsigned SEG_REDGE = 4;
  localparam int unsigned SEG_W     = 5;

  localparam logic [IDX_W-1:0] HP_IDX  = IDX_W'(HUGE_SPAN_PAGES);
  localparam logic [IDX_W-1:0] HP_MASK = IDX_W'(HUGE_SPAN_PAGES - 1);
  localparam logic [CNT_W-1:0] HP_CNT  = CNT_W'(HUGE_SPAN_PAGES);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH_BYTES);

  typedef struct packed {
    logic [PAGE_W-1:0] p0;
    logic [PAGE_W-1:0] p1;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  a_end;
    logic [IDX_W-1:0]  hlo;
    logic [IDX_W-1:0]  hhi;
    logic [IDX_W-1:0]  hi;
    logic [SEG_W-1:0]  segs;
  } rhps_plan_t;

endpackage

### rtl/rhps_ifs.sv
// valid/ready channel interfaces for range input and chunk output
interface rhps_in_if import rhps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_offset;
  logic [LEN_W-1:0]   length;

  modport source (output valid, output start_offset, output length, input ready);
  modport sink (input valid, input start_offset, input length, output ready);
endinterface

interface rhps_out_if import rhps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] first_page;
  logic [CNT_W-1:0]  page_count;
  logic              huge_chunk;
  logic              edge_page;
  logic              last_chunk;

  modport source (output valid, output first_page, output page_count,
                  output huge_chunk, output edge_page, output last_chunk, input ready);
  modport sink (input valid, input first_page, input page_count,
                input huge_chunk, input edge_page, input last_chunk, output ready);
endinterface

### rtl/range_huge_page_splitter.sv
// range splitter top level: accepted range in, page chunks out in address order
// a range is registered in the front stage, queued as a plan, then walked by the back end
// into the output register, one chunk per cycle unless out_ch.ready stalls (1 to 35 chunks per nonzero range)
// the front and a 2-entry plan queue take later ranges while chunks are still going out
// reset (rst_n low, synchronous) empties the front stage, queue and output register
// no state carries from one range to the next
module range_huge_page_splitter import rhps_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rhps_in_if.sink     in_ch,
  rhps_out_if.source  out_ch
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  rhps_plan_t push_plan, pop_plan;

  rhps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_plan  (push_plan)
  );

  rhps_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_plan  (push_plan),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_plan   (pop_plan)
  );

  rhps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_plan  (pop_plan),
    .out_ch    (out_ch)
  );

endmodule

### rtl/rhps_front.sv
// front end: takes a range, finds its last byte and builds the chunk plan
module rhps_front import rhps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rhps_in_if.sink    in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output rhps_plan_t push_plan
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [START_W-1:0] start_r, last_r;
  logic [LEN_W-1:0]   len_sat;
  logic [START_W:0]   sum;
  logic [START_W-1:0] last_nxt;
  logic               in_acc;

  logic [PAGE_W-1:0] p0, p1;
  logic              lp, rp;
  logic [IDX_W-1:0]  lo, hi, hlo, hhi;
  logic              has_whole, split, pre, post;

  assign in_ch.ready = !s1_valid_r || push_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    len_sat = (in_ch.length > MAX_LEN) ? MAX_LEN : in_ch.length;
    sum = {1'b0, in_ch.start_offset} + {{(START_W + 1 - LEN_W){1'b0}}, len_sat}
          - {{START_W{1'b0}}, 1'b1};
    // clip at the top of the address space
    last_nxt = sum[START_W] ? '1 : sum[START_W-1:0];
    // zero length produces nothing
    s1_valid_nxt = in_acc ? (in_ch.length != '0) : (s1_valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      start_r <= in_ch.start_offset;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    p0  = start_r[START_W-1:PAGE_SHIFT];
    p1  = last_r[START_W-1:PAGE_SHIFT];
    lp  = start_r[PAGE_SHIFT-1:0] != '0;
    rp  = last_r[PAGE_SHIFT-1:0] != '1;
    lo  = {1'b0, p0} + IDX_W'(lp);
    hi  = {1'b0, p1} + IDX_W'(!rp);
    // round the first whole page up to a huge boundary
    hlo = ({1'b0, p0} + (lp ? HP_IDX : HP_IDX - IDX_W'(1))) & ~HP_MASK;
    hhi = hi & ~HP_MASK;
    has_whole = lo < hi;
    split     = hlo < hhi;
    pre       = lo < hlo;
    post      = hhi < hi;

    push_plan.p0    = p0;
    push_plan.p1    = p1;
    push_plan.lo    = lo;
    push_plan.a_end = split ? hlo : hi;
    push_plan.hlo   = hlo;
    push_plan.hhi   = hhi;
    push_plan.hi    = hi;
    push_plan.segs  = '0;
    push_plan.segs[SEG_LEDGE] = lp;
    push_plan.segs[SEG_PLAIN] = has_whole && (!split || pre);
    push_plan.segs[SEG_HUGE]  = has_whole && split;
    push_plan.segs[SEG_POST]  = has_whole && split && post;
    // a range inside one page, but not the whole page, gives a single edge chunk
    push_plan.segs[SEG_REDGE] = rp && !(lp && (p1 == p0));
  end

  assign push_valid = s1_valid_r;

endmodule

### rtl/rhps_fifo.sv
// short plan queue between front and back
module rhps_fifo import rhps_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  rhps_plan_t push_plan,
  output logic       pop_valid,
  input  logic       pop_ready,
  output rhps_plan_t pop_plan
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  rhps_plan_t         slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = cnt_r != FULL_CNT;
  assign pop_valid  = cnt_r != '0;
  assign pop_plan   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_QW'(do_push) - CNT_QW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_plan;
    end
  end

endmodule

### rtl/rhps_back.sv
// back end: walks a chunk plan and emits one chunk per cycle unless out_ch.ready stalls
module rhps_back import rhps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  rhps_plan_t pop_plan,
  rhps_out_if.source out_ch
);

`include "range_huge_page_splitter_macros.svh"

  rhps_plan_t        plan_r;
  logic [SEG_W-1:0]  pend_r, pend_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt, k_step;
  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              huge_r, huge_nxt, edge_r, edge_nxt, last_r, last_nxt;

  logic              busy, out_free, adv, pop;
  logic [SEG_W-1:0]  sel, clr, rem;
  logic              huge_more, is_last;

  always_comb begin
    busy      = pend_r != '0;
    out_free  = !out_valid_r || out_ch.ready;
    adv       = busy && out_free;
    sel       = pend_r & (~pend_r + SEG_W'(1));
    k_step    = k_r + HP_IDX;
    // the huge kind stays pending until the last aligned span
    huge_more = sel[SEG_HUGE] && (k_step != plan_r.hhi);
    clr       = sel;
    if (huge_more) begin
      clr[SEG_HUGE] = 1'b0;
    end
    rem       = pend_r & ~clr;
    is_last   = rem == '0;
    pop       = pop_valid && (!busy || (adv && is_last));

    page_nxt = page_r;
    cnt_nxt  = cnt_r;
    huge_nxt = 1'b0;
    edge_nxt = 1'b0;
    if (sel[SEG_LEDGE]) begin
      page_nxt = plan_r.p0;
      cnt_nxt  = CNT_W'(1);
      edge_nxt = 1'b1;
    end else if (sel[SEG_PLAIN]) begin
      page_nxt = plan_r.lo[PAGE_W-1:0];
      cnt_nxt  = CNT_W'(plan_r.a_end - plan_r.lo);
    end else if (sel[SEG_HUGE]) begin
      page_nxt = k_r[PAGE_W-1:0];
      cnt_nxt  = HP_CNT;
      huge_nxt = 1'b1;
    end else if (sel[SEG_POST]) begin
      page_nxt = plan_r.hhi[PAGE_W-1:0];
      cnt_nxt  = CNT_W'(plan_r.hi - plan_r.hhi);
    end else begin
      page_nxt = plan_r.p1;
      cnt_nxt  = CNT_W'(1);
      edge_nxt = 1'b1;
    end
    last_nxt = is_last;

    if (pop) begin
      pend_nxt = pop_plan.segs;
      k_nxt    = pop_plan.hlo;
    end else if (adv) begin
      pend_nxt = rem;
      k_nxt    = sel[SEG_HUGE] ? k_step : k_r;
    end else begin
      pend_nxt = pend_r;
      k_nxt    = k_r;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign pop_ready = !busy || (adv && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (pop) begin
      plan_r <= pop_plan;
    end
    if (adv) begin
      page_r <= page_nxt;
      cnt_r  <= cnt_nxt;
      huge_r <= huge_nxt;
      edge_r <= edge_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.first_page = page_r;
  assign out_ch.page_count = cnt_r;
  assign out_ch.huge_chunk = huge_r;
  assign out_ch.edge_page  = edge_r;
  assign out_ch.last_chunk = last_r;

  `RHPS_ASSERT_IMP(a_huge_aligned, out_valid_r && huge_r, (cnt_r == HP_CNT) && (page_r[HUGE_SHIFT-1:0] == '0), "huge chunk not aligned or wrong size")
  `RHPS_ASSERT_IMP(a_edge_single, out_valid_r && edge_r, (cnt_r == CNT_W'(1)) && !huge_r, "edge chunk is not one plain page")
  `RHPS_ASSERT_IMP(a_huge_in_span, pend_r[SEG_HUGE], k_r < plan_r.hhi, "huge walk ran past its span")
  `RHPS_ASSERT_NXT(a_more_follows, adv && !is_last, pend_r != '0, "plan dropped before its last chunk")

endmodule
